// File: design/tdp_pkg.sv
`timescale 1ns / 1ps

package tdp_pkg;

    localparam int unsigned FIRST_DIVISOR = 2;
    localparam int unsigned OUT_TDATA_W   = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic start;
    } t_rem_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } t_rem_stat;

endpackage

// File: design/tdp_rem.sv
`timescale 1ns / 1ps

module tdp_rem #(
    parameter int unsigned NUMBER_WIDTH = 32,
    parameter int unsigned DIV_WIDTH    = 17
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  tdp_pkg::t_rem_ctrl       i_ctrl,
    input  logic [NUMBER_WIDTH-1:0]  i_dividend,
    input  logic [DIV_WIDTH-1:0]     i_divisor,
    output tdp_pkg::t_rem_stat       o_stat
);

    localparam int unsigned CW = $clog2(NUMBER_WIDTH + 1);

    logic                    r_busy;
    logic [CW-1:0]           r_cnt;
    logic [NUMBER_WIDTH-1:0] r_shift;
    logic [DIV_WIDTH-1:0]    r_rem;

    logic [DIV_WIDTH:0]      w_trial;
    logic [DIV_WIDTH:0]      w_diff;
    logic [DIV_WIDTH-1:0]    n_rem;

    // one dividend bit per cycle, MSB first, restoring step
    always_comb begin
        w_trial = {r_rem, r_shift[NUMBER_WIDTH-1]};
        w_diff  = w_trial - {1'b0, i_divisor};
        if (w_trial >= {1'b0, i_divisor}) begin
            n_rem = w_diff[DIV_WIDTH-1:0];
        end else begin
            n_rem = w_trial[DIV_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctrl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NUMBER_WIDTH);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_shift <= {r_shift[NUMBER_WIDTH-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && (r_cnt == '0);
    assign o_stat.zero = (r_rem == '0);

endmodule

// File: design/trial_division_prime_test.sv
`timescale 1ns / 1ps
// Trial-division primality test.
// Input channel (i_s_axis_*): one beat carries one unsigned number in the
// low NUMBER_WIDTH bits of tdata. Output channel (o_m_axis_*): one beat per
// input beat, prime flag in tdata bit 0 (1 = prime).
// Zero and one are answered without any division. Otherwise divisors
// 2, 3, 4 ... are tried while the divisor squared does not exceed the
// number; the square is kept by adding 2d+1 per step, no multiplier.
// Each remainder comes from a bit-serial divider that takes one dividend
// bit per cycle; a compare step comes before each divisor. For a 32-bit
// prime near 2^32, 65534 divisors are tried.
// One number is worked on at a time; tready is high only while idle, from
// the cycle after the result is loaded.
// A finished result sits in an output register, so the next number is
// accepted while the receiver stalls; that number's result waits until the
// register is free. Reset (synchronous, active low) drops any number in
// progress and any pending result.
module trial_division_prime_test #(
    parameter int unsigned NUMBER_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [NUMBER_WIDTH-1:0] number, zero fill above
    input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]   i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [0] prime_flag, zero fill above
    output logic [tdp_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);

    localparam int unsigned DW = (NUMBER_WIDTH + 1) / 2 + 1;
    localparam int unsigned SW = NUMBER_WIDTH + 1;

    tdp_pkg::t_state    r_state;
    tdp_pkg::t_state    n_state;
    logic [NUMBER_WIDTH-1:0] r_num;
    logic [DW-1:0]           r_div;
    logic [SW-1:0]           r_sq;
    logic                    r_prime;
    logic                    r_out_valid;
    logic                    r_out_flag;

    tdp_pkg::t_rem_ctrl w_ctrl;
    tdp_pkg::t_rem_stat w_stat;
    logic               w_in_beat;
    logic               w_out_beat;
    logic               w_load_out;
    logic               w_small;
    logic               w_sq_over;

    assign o_s_axis_tready = (r_state == tdp_pkg::ST_IDLE);
    assign w_in_beat       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_beat      = r_out_valid && i_m_axis_tready;
    assign w_small   = i_s_axis_tdata[NUMBER_WIDTH-1:0]
                       < NUMBER_WIDTH'(tdp_pkg::FIRST_DIVISOR);
    assign w_sq_over = r_sq > {1'b0, r_num};

    always_comb begin
        n_state      = r_state;
        w_ctrl.start = 1'b0;
        w_load_out   = 1'b0;
        case (r_state)
            tdp_pkg::ST_IDLE: begin
                if (w_in_beat) begin
                    n_state = w_small ? tdp_pkg::ST_FINISH : tdp_pkg::ST_CHECK;
                end
            end
            tdp_pkg::ST_CHECK: begin
                if (w_sq_over) begin
                    n_state = tdp_pkg::ST_FINISH;
                end else begin
                    w_ctrl.start = 1'b1;
                    n_state      = tdp_pkg::ST_DIV;
                end
            end
            tdp_pkg::ST_DIV: begin
                if (w_stat.done) begin
                    n_state = w_stat.zero ? tdp_pkg::ST_FINISH : tdp_pkg::ST_CHECK;
                end
            end
            tdp_pkg::ST_FINISH: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = tdp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tdp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            tdp_pkg::ST_IDLE: begin
                if (w_in_beat) begin
                    r_num   <= i_s_axis_tdata[NUMBER_WIDTH-1:0];
                    r_div   <= DW'(tdp_pkg::FIRST_DIVISOR);
                    r_sq    <= SW'(tdp_pkg::FIRST_DIVISOR * tdp_pkg::FIRST_DIVISOR);
                    r_prime <= 1'b0;
                end
            end
            tdp_pkg::ST_CHECK: begin
                if (w_sq_over) begin
                    r_prime <= 1'b1;
                end else begin
                    // advance square to (d+1)^2 while the divider runs on d
                    r_sq <= r_sq + SW'({r_div, 1'b1});
                end
            end
            tdp_pkg::ST_DIV: begin
                if (w_stat.done) begin
                    r_div <= r_div + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (w_out_beat) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_flag <= r_prime;
        end
    end

    tdp_rem #(
        .NUMBER_WIDTH (NUMBER_WIDTH),
        .DIV_WIDTH    (DW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_dividend (r_num),
        .i_divisor  (r_div),
        .o_stat     (w_stat)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(tdp_pkg::OUT_TDATA_W-1){1'b0}}, r_out_flag};

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (r_state == tdp_pkg::ST_DIV))
        else $error("divider finished outside a division");

    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdp_pkg::ST_DIV) |-> w_stat.busy)
        else $error("division state without a running divider");

    a_prime_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdp_pkg::ST_FINISH && r_prime) |-> w_sq_over)
        else $error("prime reported before the square passed the number");

    a_divisor_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdp_pkg::ST_DIV)
        |-> (r_div >= DW'(tdp_pkg::FIRST_DIVISOR)))
        else $error("division started with a divisor below two");

endmodule
